// ===== src/trpd_pkg.sv =====
// shared constants and types for the tga rle pixel decoder
`timescale 1ns / 1ps
`default_nettype none

package trpd_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int PAL_AW      = $clog2(PAL_ENTRIES);

    // request codes
    localparam logic [1:0] REQ_PAL_WRITE = 2'd0;
    localparam logic [1:0] REQ_DATA      = 2'd1;
    localparam logic [1:0] REQ_START     = 2'd2;

    // image kinds
    localparam logic [1:0] KIND_PALETTE     = 2'd0;
    localparam logic [1:0] KIND_GREY        = 2'd1;
    localparam logic [1:0] KIND_TRUE_COLOUR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_IMAGE_KIND = 2'd0;
    localparam logic [1:0] CFG_RLE_ENABLE = 2'd1;
    localparam logic [1:0] CFG_BPP        = 2'd2;
    localparam logic [1:0] CFG_PIXEL_CNT  = 2'd3;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [7:0] COUNT_MASK   = 8'h7f;

    // one finished pixel on its way to the colour stage
    typedef struct packed {
        logic [31:0] raw;
        logic [2:0]  bpp;
        logic [1:0]  kind;
        logic [7:0]  repeat_cnt;
        logic [31:0] start_index;
        logic        done;
    } pix_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        widen5 = {v, v[4:2]};
    endfunction

endpackage

`default_nettype wire

// ===== src/tga_rle_pixel_decoder.sv =====
// tga pixel data decoder: packet parsing, pixel assembly, palette and colour expansion
`timescale 1ns / 1ps
`default_nettype none

//  channel  | ports                                              | moves
//  ---------+----------------------------------------------------+---------------------------
//  input    | s_valid s_ready s_req_type s_pal_index ...          | one request per transfer
//  result   | m_valid m_ready m_argb m_repeat_res ...             | one pixel or run per transfer
//  config   | cfg_we cfg_index cfg_wdata                          | one register write, no wait
//
//  one request per cycle is taken while s_ready is high; a pixel's last byte goes into the
//  stage register, then its colour, formed with the palette ram read, into the output register
//  no clearing pass after reset: control state clears at reset, the palette is
//  undefined until written
//  a stalled result holds only the output register and the stage in front of it;
//  s_ready drops only when both are full and m_ready is low

module tga_rle_pixel_decoder (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_pal_index,
    input  wire logic [23:0] s_pal_color,
    input  wire logic [7:0]  s_data_byte,

    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_argb,
    output logic [7:0]       m_repeat_res,
    output logic [31:0]      m_start_index,
    output logic             m_image_done,

    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);

    // configuration registers
    logic [1:0]  kind_reg;
    logic        rle_en_reg;
    logic [2:0]  bpp_cfg_reg;
    logic [31:0] pix_cnt_reg;

    // packet and pixel state
    logic        await_reg,   await_next;
    logic        run_reg,     run_next;
    logic [7:0]  left_reg,    left_next;
    logic [1:0]  phase_reg,   phase_next;
    logic [31:0] bytes_reg,   bytes_next;
    logic [31:0] emitted_reg, emitted_next;
    logic [31:0] remain_reg,  remain_next;   // pixel count minus emitted, kept alongside
    logic        exhaust_reg, exhaust_next;  // all pixels already produced

    // palette ram and its registered read
    logic [23:0]                   pal_mem [trpd_pkg::PAL_ENTRIES];
    logic [23:0]                   pal_rd_reg;
    logic [trpd_pkg::PAL_AW-1:0]   pal_addr;

    // stage between state update and the output register
    logic               p1_valid_reg, p1_valid_next;
    trpd_pkg::pix_t     p1_reg, p1_next;

    // output register
    logic               m_valid_reg;
    logic [31:0]        m_argb_reg;
    logic [7:0]         m_repeat_reg;
    logic [31:0]        m_start_reg;
    logic               m_done_reg;
    logic [31:0]        colour;

    logic s_xfer, out_free, p1_move;
    logic [2:0] bpp_eff, got;
    logic [31:0] raw_full;
    logic [7:0]  rep;

    assign out_free = !m_valid_reg || m_ready;
    assign p1_move  = p1_valid_reg && out_free;
    assign s_ready  = !p1_valid_reg || out_free;
    assign s_xfer   = s_valid && s_ready;

    // stored size clamped to 1..4
    always_comb begin
        if (bpp_cfg_reg == 3'd0) begin
            bpp_eff = 3'd1;
        end else if (bpp_cfg_reg > 3'd4) begin
            bpp_eff = 3'd4;
        end else begin
            bpp_eff = bpp_cfg_reg;
        end
    end

    assign got      = {1'b0, phase_reg} + 3'd1;
    assign raw_full = bytes_reg | ({24'd0, s_data_byte} << {phase_reg, 3'b000});
    // the palette index is always the lowest pixel byte
    assign pal_addr = (phase_reg == 2'd0) ? s_data_byte : bytes_reg[7:0];

    // packet walk and pixel assembly for one request, and the remaining count on a pixel count write
    always_comb begin
        await_next    = await_reg;
        run_next      = run_reg;
        left_next     = left_reg;
        phase_next    = phase_reg;
        bytes_next    = bytes_reg;
        emitted_next  = emitted_reg;
        remain_next   = remain_reg;
        exhaust_next  = exhaust_reg;
        p1_valid_next = p1_move ? 1'b0 : p1_valid_reg;
        p1_next       = p1_reg;
        rep           = 8'd1;

        if (s_xfer) begin
            case (s_req_type)
                trpd_pkg::REQ_START: begin
                    await_next   = rle_en_reg;
                    run_next     = 1'b0;
                    left_next    = 8'd0;
                    phase_next   = 2'd0;
                    bytes_next   = 32'd0;
                    emitted_next = 32'd0;
                    remain_next  = pix_cnt_reg;
                    exhaust_next = (pix_cnt_reg == 32'd0);
                end
                trpd_pkg::REQ_DATA: begin
                    if (!exhaust_reg) begin
                        if (rle_en_reg && await_reg) begin
                            // packet header byte
                            left_next  = (s_data_byte & trpd_pkg::COUNT_MASK) + 8'd1;
                            run_next   = s_data_byte[7];
                            await_next = 1'b0;
                        end else if (got < bpp_eff) begin
                            phase_next = got[1:0];
                            bytes_next = raw_full;
                        end else begin
                            phase_next = 2'd0;
                            bytes_next = 32'd0;
                            if (rle_en_reg) begin
                                if (run_reg) begin
                                    rep        = (left_reg != 8'd0) ? left_reg : 8'd1;
                                    left_next  = 8'd0;
                                    await_next = 1'b1;
                                end else if (left_reg <= 8'd1) begin
                                    left_next  = 8'd0;
                                    await_next = 1'b1;
                                end else begin
                                    left_next  = left_reg - 8'd1;
                                end
                            end
                            // clip a run to what is left of the image
                            if (remain_reg[31:8] == 24'd0 && rep > remain_reg[7:0]) begin
                                rep = remain_reg[7:0];
                            end
                            p1_valid_next       = 1'b1;
                            p1_next.raw         = raw_full;
                            p1_next.bpp         = bpp_eff;
                            p1_next.kind        = kind_reg;
                            p1_next.repeat_cnt  = rep;
                            p1_next.start_index = emitted_reg;
                            p1_next.done        = ({24'd0, rep} == remain_reg);
                            emitted_next        = emitted_reg + {24'd0, rep};
                            remain_next         = remain_reg - {24'd0, rep};
                            exhaust_next        = ({24'd0, rep} == remain_reg);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        if (cfg_we && cfg_index == trpd_pkg::CFG_PIXEL_CNT) begin
            remain_next  = cfg_wdata - emitted_reg;
            exhaust_next = (cfg_wdata <= emitted_reg);
        end
    end

    // colour formation from the stage register and the palette read
    always_comb begin
        if (p1_reg.kind == trpd_pkg::KIND_PALETTE) begin
            colour = {trpd_pkg::ALPHA_OPAQUE, pal_rd_reg};
        end else if (p1_reg.kind == trpd_pkg::KIND_GREY || p1_reg.bpp == 3'd1) begin
            colour = {trpd_pkg::ALPHA_OPAQUE, p1_reg.raw[7:0], p1_reg.raw[7:0],
                      p1_reg.raw[7:0]};
        end else if (p1_reg.bpp == 3'd2) begin
            colour = {trpd_pkg::ALPHA_OPAQUE,
                      trpd_pkg::widen5(p1_reg.raw[14:10]),
                      trpd_pkg::widen5(p1_reg.raw[9:5]),
                      trpd_pkg::widen5(p1_reg.raw[4:0])};
        end else if (p1_reg.bpp == 3'd3) begin
            colour = {trpd_pkg::ALPHA_OPAQUE, p1_reg.raw[23:0]};
        end else begin
            colour = p1_reg.raw;
        end
    end

    // palette ram: write on palette transfers, read on data transfers
    always_ff @(posedge aclk) begin
        if (s_xfer && s_req_type == trpd_pkg::REQ_PAL_WRITE) begin
            pal_mem[s_pal_index] <= s_pal_color;
        end
        if (s_xfer && s_req_type == trpd_pkg::REQ_DATA) begin
            pal_rd_reg <= pal_mem[pal_addr];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg     <= trpd_pkg::KIND_TRUE_COLOUR;
            rle_en_reg   <= 1'b0;
            bpp_cfg_reg  <= 3'd3;
            pix_cnt_reg  <= 32'd1;
            await_reg    <= 1'b0;
            run_reg      <= 1'b0;
            left_reg     <= 8'd0;
            phase_reg    <= 2'd0;
            bytes_reg    <= 32'd0;
            emitted_reg  <= 32'd0;
            remain_reg   <= 32'd1;
            exhaust_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    trpd_pkg::CFG_IMAGE_KIND: kind_reg    <= cfg_wdata[1:0];
                    trpd_pkg::CFG_RLE_ENABLE: rle_en_reg  <= cfg_wdata[0];
                    trpd_pkg::CFG_BPP:        bpp_cfg_reg <= cfg_wdata[2:0];
                    trpd_pkg::CFG_PIXEL_CNT:  pix_cnt_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            await_reg    <= await_next;
            run_reg      <= run_next;
            left_reg     <= left_next;
            phase_reg    <= phase_next;
            bytes_reg    <= bytes_next;
            emitted_reg  <= emitted_next;
            remain_reg   <= remain_next;
            exhaust_reg  <= exhaust_next;
            p1_valid_reg <= p1_valid_next;
            if (out_free) begin
                m_valid_reg <= p1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        p1_reg <= p1_next;
        if (p1_move) begin
            m_argb_reg   <= colour;
            m_repeat_reg <= p1_reg.repeat_cnt;
            m_start_reg  <= p1_reg.start_index;
            m_done_reg   <= p1_reg.done;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_argb        = m_argb_reg;
    assign m_repeat_res  = m_repeat_reg;
    assign m_start_index = m_start_reg;
    assign m_image_done  = m_done_reg;

    // remaining count tracks pixel count minus emitted
    a_remain_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(remain_reg + emitted_reg) == pix_cnt_reg)
        else $error("remaining count out of step with emitted count");

    // nothing is produced once the image is complete
    a_no_emit_exhausted: assert property (@(posedge aclk) disable iff (!aresetn)
        exhaust_reg && !(cfg_we && cfg_index == trpd_pkg::CFG_PIXEL_CNT)
        |=> !($rose(p1_valid_reg)))
        else $error("pixel produced after image completed");

    // a queued result never carries a zero repeat
    a_repeat_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> p1_reg.repeat_cnt != 8'd0)
        else $error("zero repeat count in pipeline");

    // input stalls only when both stages are full and the output is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> p1_valid_reg && m_valid_reg && !m_ready)
        else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ===== tb/sv/tga_rle_pixel_decoder_test.sv =====
// self-checking testbench for the tga rle pixel decoder: directed and random pixel streams
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_test;

    // codes the package leaves out
    localparam logic [1:0]  REQ_UNKNOWN      = 2'd3;
    localparam logic [1:0]  KIND_SPARE       = 2'd3;
    localparam logic [31:0] PIXEL_COUNT_MAX  = 32'd4294836225;

    // a pixel leaves through the stage and output registers after its last byte; leave a margin on top
    localparam int SETTLE_CYCLES   = 8;

    // one expected pixel or run, in the order the block must deliver them
    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  run_length;
        logic [31:0] first_pixel;
        logic        completes;
    } pixel_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_req_type;
    logic [7:0]  s_pal_index;
    logic [23:0] s_pal_color;
    logic [7:0]  s_data_byte;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_argb;
    logic [7:0]  m_repeat_res;
    logic [31:0] m_start_index;
    logic        m_image_done;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    // expected pixels not yet seen on the result side
    pixel_result_t pending_pixels[$];
    int            mismatch_count;
    int            transfers_sent;

    // idling controls for the stimulus and the result sink
    bit src_gaps;
    bit sink_gaps;
    int sink_hold_cycles;

    // decoder state as the testbench sees it
    logic [23:0] palette[trpd_pkg::PAL_ENTRIES];
    logic [1:0]  cfg_kind;
    logic        cfg_rle;
    logic [2:0]  cfg_bpp;
    logic [31:0] cfg_pix_cnt;
    logic        await_hdr;
    logic        run_pkt;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_phase;
    logic [31:0] pix_bytes;
    logic [31:0] emitted;

    tga_rle_pixel_decoder i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_pal_index   (s_pal_index),
        .s_pal_color   (s_pal_color),
        .s_data_byte   (s_data_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_argb        (m_argb),
        .m_repeat_res  (m_repeat_res),
        .m_start_index (m_start_index),
        .m_image_done  (m_image_done),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // decoder prediction
    // ------------------------------------------------------------------

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return (8'(v) << 3) | (8'(v) >> 2);
    endfunction

    // colour of one gathered pixel under the current image kind
    function automatic logic [31:0] pixel_colour(input logic [31:0] raw,
                                                 input logic [2:0] pix_size);
        if (cfg_kind == trpd_pkg::KIND_PALETTE)
            return {trpd_pkg::ALPHA_OPAQUE, palette[raw[7:0]]};
        // grey, and true colour stored in a single byte
        if (cfg_kind == trpd_pkg::KIND_GREY || pix_size == 3'd1)
            return {trpd_pkg::ALPHA_OPAQUE, {3{raw[7:0]}}};
        // 5:5:5, top bit ignored
        if (pix_size == 3'd2)
            return {trpd_pkg::ALPHA_OPAQUE, expand5(raw[14:10]), expand5(raw[9:5]),
                    expand5(raw[4:0])};
        if (pix_size == 3'd3)
            return {trpd_pkg::ALPHA_OPAQUE, raw[23:0]};
        return raw;
    endfunction

    function automatic void reset_decoder_state();
        cfg_kind    = trpd_pkg::KIND_TRUE_COLOUR;
        cfg_rle     = 1'b0;
        cfg_bpp     = 3'd3;
        cfg_pix_cnt = 32'd1;
        await_hdr   = 1'b0;
        run_pkt     = 1'b0;
        pkt_left    = 8'd0;
        byte_phase  = 2'd0;
        pix_bytes   = 32'd0;
        emitted     = 32'd0;
    endfunction

    // advances the state by one accepted request; returns 1 with the pixel it yields
    function automatic logic decode_request(input logic [1:0] req, input logic [7:0] idx,
                                            input logic [23:0] col, input logic [7:0] dbyte,
                                            output pixel_result_t res);
        logic [2:0]  pix_size;
        logic [2:0]  gathered;
        logic [31:0] raw;
        logic [31:0] run_n;
        logic [31:0] left;
        res = '0;
        decode_request = 1'b0;
        case (req)
            trpd_pkg::REQ_PAL_WRITE: begin
                palette[idx] = col;
            end
            trpd_pkg::REQ_START: begin
                // palette survives a restart
                await_hdr  = cfg_rle;
                run_pkt    = 1'b0;
                pkt_left   = 8'd0;
                byte_phase = 2'd0;
                pix_bytes  = 32'd0;
                emitted    = 32'd0;
            end
            trpd_pkg::REQ_DATA: begin
                // bytes beyond the pixel count are dropped outright
                if (emitted < cfg_pix_cnt) begin
                    if (cfg_rle && await_hdr) begin
                        pkt_left  = (dbyte & trpd_pkg::COUNT_MASK) + 8'd1;
                        run_pkt   = dbyte[7];
                        await_hdr = 1'b0;
                    end else begin
                        pix_size = cfg_bpp == 3'd0 ? 3'd1 : (cfg_bpp > 3'd4 ? 3'd4 : cfg_bpp);
                        pix_bytes = pix_bytes | (32'(dbyte) << (8 * byte_phase));
                        gathered  = 3'(byte_phase) + 3'd1;
                        if (gathered < pix_size) begin
                            byte_phase = gathered[1:0];
                        end else begin
                            raw        = pix_bytes;
                            byte_phase = 2'd0;
                            pix_bytes  = 32'd0;
                            run_n      = 32'd1;
                            if (cfg_rle) begin
                                if (run_pkt) begin
                                    run_n     = pkt_left != 8'd0 ? 32'(pkt_left) : 32'd1;
                                    pkt_left  = 8'd0;
                                    await_hdr = 1'b1;
                                end else if (pkt_left <= 8'd1) begin
                                    // also a pixel with no packet open
                                    pkt_left  = 8'd0;
                                    await_hdr = 1'b1;
                                end else begin
                                    pkt_left = pkt_left - 8'd1;
                                end
                            end
                            // runs are clipped at the end of the image
                            left = cfg_pix_cnt - emitted;
                            if (run_n > left)
                                run_n = left;
                            res.argb        = pixel_colour(raw, pix_size);
                            res.run_length  = run_n[7:0];
                            res.first_pixel = emitted;
                            res.completes   = run_n == left;
                            emitted         = emitted + run_n;
                            decode_request  = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h expected %h at %0t ns", what, got, want, $time);
    endtask

    // every result transfer is held against the oldest expected pixel
    always @(posedge aclk) begin : check_results
        pixel_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch("result with nothing expected", m_argb, 32'd0);
            end else begin
                want = pending_pixels.pop_front();
                if (m_argb !== want.argb)
                    report_mismatch("argb", m_argb, want.argb);
                if (m_repeat_res !== want.run_length)
                    report_mismatch("repeat_res", 32'(m_repeat_res), 32'(want.run_length));
                if (m_start_index !== want.first_pixel)
                    report_mismatch("start_index", m_start_index, want.first_pixel);
                if (m_image_done !== want.completes)
                    report_mismatch("image_done", 32'(m_image_done), 32'(want.completes));
            end
        end
    end

    // result sink: random idling, plus a long hold-off counted here when asked for
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_ready = 1'b0;
                sink_hold_cycles--;
            end else if (sink_gaps) begin
                m_ready = $urandom_range(0, 99) >= 20;
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one request transfer; prediction happens on the accepting edge
    task automatic send_request(input logic [1:0] req, input logic [7:0] idx,
                                input logic [23:0] col, input logic [7:0] dbyte);
        pixel_result_t want;
        @(negedge aclk);
        if (src_gaps) begin
            while ($urandom_range(0, 99) < 20) begin
                s_valid = 1'b0;
                @(negedge aclk);
            end
        end
        s_valid     = 1'b1;
        s_req_type  = req;
        s_pal_index = idx;
        s_pal_color = col;
        s_data_byte = dbyte;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (decode_request(req, idx, col, dbyte, want))
            pending_pixels.push_back(want);
        transfers_sent++;
    endtask

    task automatic send_data(input logic [7:0] dbyte);
        send_request(trpd_pkg::REQ_DATA, 8'($urandom), 24'($urandom), dbyte);
    endtask

    // stored pixel, least significant byte first
    task automatic send_pixel(input logic [31:0] value, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            send_data(value[8 * i +: 8]);
    endtask

    // no request in flight and every expected pixel delivered
    task automatic wait_until_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (pending_pixels.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        wait_until_idle();
        cfg_we    = 1'b1;
        cfg_index = index;
        cfg_wdata = value;
        case (index)
            trpd_pkg::CFG_IMAGE_KIND: cfg_kind    = value[1:0];
            trpd_pkg::CFG_RLE_ENABLE: cfg_rle     = value[0];
            trpd_pkg::CFG_BPP:        cfg_bpp     = value[2:0];
            trpd_pkg::CFG_PIXEL_CNT:  cfg_pix_cnt = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // full register set, then a start transfer to open the image
    task automatic set_image(input logic [1:0] kind, input logic rle, input logic [2:0] bpp,
                             input logic [31:0] count);
        write_register(trpd_pkg::CFG_IMAGE_KIND, 32'(kind));
        write_register(trpd_pkg::CFG_RLE_ENABLE, 32'(rle));
        write_register(trpd_pkg::CFG_BPP, 32'(bpp));
        write_register(trpd_pkg::CFG_PIXEL_CNT, count);
        send_request(trpd_pkg::REQ_START, 8'($urandom), 24'($urandom), 8'($urandom));
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every entry is written before any paletted pixel is looked up
    task automatic test_palette_load();
        logic [23:0] col;
        for (int i = 0; i < trpd_pkg::PAL_ENTRIES; i++) begin
            col = i == 0 ? 24'h000000 :
                  (i == trpd_pkg::PAL_ENTRIES - 1 ? 24'hffffff : 24'($urandom));
            send_request(trpd_pkg::REQ_PAL_WRITE, 8'(i), col, 8'($urandom));
        end
    endtask

    task automatic test_true_colour_formats();
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd4, 32'd1);
        send_pixel(32'hff00_80ff, 4);
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd3, 32'd1);
        send_pixel(32'h00a5_5aff, 3);
        // top bit of a 16-bit pixel set, fields at both ends
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd2, 32'd1);
        send_pixel(32'h0000_fc1f, 2);
        // single byte true colour comes out grey
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd1, 32'd1);
        send_data(8'h00);
    endtask

    task automatic test_grey_and_palette();
        set_image(trpd_pkg::KIND_GREY, 1'b0, 3'd1, 32'd1);
        send_data(8'hff);
        // only the lowest byte of a wide grey or paletted pixel counts
        set_image(trpd_pkg::KIND_GREY, 1'b0, 3'd2, 32'd1);
        send_pixel(32'h0000_ff37, 2);
        set_image(trpd_pkg::KIND_PALETTE, 1'b0, 3'd1, 32'd2);
        send_data(8'h00);
        send_data(8'hff);
        set_image(trpd_pkg::KIND_PALETTE, 1'b0, 3'd2, 32'd1);
        send_pixel(32'h0000_a905, 2);
    endtask

    task automatic test_run_length_packets();
        set_image(trpd_pkg::KIND_GREY, 1'b1, 3'd1, 32'd132);
        // longest run
        send_data(8'hff);
        send_data(8'h5a);
        // two stored pixels
        send_data(8'h01);
        send_data(8'h10);
        send_data(8'h20);
        // run of four clipped to the last two pixels
        send_data(8'h83);
        send_data(8'h30);
        // image already complete: dropped
        send_data(8'h44);
        // zero pixel count drops everything
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd1, 32'd0);
        send_data(8'h55);
        set_image(trpd_pkg::KIND_GREY, 1'b0, 3'd1, PIXEL_COUNT_MAX);
        send_data(8'h66);
    endtask

    task automatic test_odd_settings();
        // spare kind behaves as true colour
        set_image(KIND_SPARE, 1'b0, 3'd2, 32'd1);
        send_pixel(32'h0000_2b6d, 2);
        // zero bytes per pixel reads as one, anything above four as four
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd0, 32'd1);
        send_data(8'h7e);
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd7, 32'd1);
        send_pixel(32'h1234_5678, 4);
        send_request(REQ_UNKNOWN, 8'hff, 24'hffffff, 8'hff);
        // size and packet mode changed part way through an image
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd3, 32'd4);
        send_data(8'h11);
        write_register(trpd_pkg::CFG_BPP, 32'd1);
        send_data(8'h22);
        write_register(trpd_pkg::CFG_RLE_ENABLE, 32'd1);
        send_data(8'h33);
        send_data(8'h80);
        send_data(8'h44);
    endtask

    // result side held off long enough for the block to back up onto its input
    task automatic test_output_stall();
        set_image(trpd_pkg::KIND_TRUE_COLOUR, 1'b0, 3'd1, 32'd200);
        sink_hold_cycles = 400;
        for (int i = 0; i < 120; i++)
            send_data(8'($urandom));
    endtask

    // random settings and mostly well-formed packet streams, with some noise
    task automatic test_random_images();
        int          first_transfer;
        int          pick;
        int          target;
        int          produced;
        int          stored;
        int          run_len;
        logic [1:0]  kind;
        logic        rle;
        logic        is_run;
        logic [2:0]  bpp;
        logic [2:0]  pix_size;
        logic [31:0] count;
        first_transfer = transfers_sent;
        while (transfers_sent - first_transfer < 1100) begin
            // a stretch in the middle runs flat out on both sides
            pick      = transfers_sent - first_transfer;
            src_gaps  = pick < 350 || pick >= 650;
            sink_gaps = src_gaps;

            kind = 2'($urandom_range(0, 3));
            rle  = $urandom_range(0, 9) < 7;
            pick = $urandom_range(0, 11);
            bpp  = pick == 0 ? 3'd0 :
                   (pick == 1 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(1, 4)));
            pix_size = bpp == 3'd0 ? 3'd1 : (bpp > 3'd4 ? 3'd4 : bpp);
            pick  = $urandom_range(0, 19);
            count = pick == 0 ? 32'd0 :
                    (pick == 1 ? PIXEL_COUNT_MAX : 32'($urandom_range(1, 48)));
            target = (count >= 32'd1 && count <= 32'd48) ? int'(count) : $urandom_range(4, 24);
            set_image(kind, rle, bpp, count);

            produced = 0;
            while (produced < target) begin
                case ($urandom_range(0, 39))
                    0: send_request(trpd_pkg::REQ_PAL_WRITE, 8'($urandom), 24'($urandom),
                                    8'($urandom));
                    1: send_request(REQ_UNKNOWN, 8'($urandom), 24'($urandom), 8'($urandom));
                    // stray byte knocks the packet framing over
                    2: send_data(8'($urandom));
                    // restart part way through
                    3: send_request(trpd_pkg::REQ_START, 8'($urandom), 24'($urandom),
                                    8'($urandom));
                    default: ;
                endcase
                if (rle) begin
                    is_run  = $urandom_range(0, 1);
                    pick    = $urandom_range(0, 15);
                    run_len = is_run ? (pick == 0 ? 128 : $urandom_range(1, 8)) :
                              (pick == 0 ? $urandom_range(9, 32) : $urandom_range(1, 6));
                    send_data({is_run, 7'(run_len - 1)});
                    stored = is_run ? 1 : run_len;
                end else begin
                    run_len = 1;
                    stored  = 1;
                end
                repeat (stored) send_pixel($urandom, int'(pix_size));
                produced += run_len;
            end
            // trailing bytes, dropped when the image is already complete
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) send_data(8'($urandom));
        end
        src_gaps  = 1'b1;
        sink_gaps = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial begin
        aresetn          = 1'b0;
        s_valid          = 1'b0;
        s_req_type       = trpd_pkg::REQ_DATA;
        s_pal_index      = 8'd0;
        s_pal_color      = 24'd0;
        s_data_byte      = 8'd0;
        cfg_we           = 1'b0;
        cfg_index        = trpd_pkg::CFG_IMAGE_KIND;
        cfg_wdata        = 32'd0;
        src_gaps         = 1'b1;
        sink_gaps        = 1'b1;
        sink_hold_cycles = 0;
        mismatch_count   = 0;
        transfers_sent   = 0;
        reset_decoder_state();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_palette_load();
        test_true_colour_formats();
        test_grey_and_palette();
        test_run_length_packets();
        test_odd_settings();
        test_output_stall();
        test_random_images();

        wait_until_idle();
        if (mismatch_count == 0)
            $display("PASS tga_rle_pixel_decoder");
        else
            $display("FAIL tga_rle_pixel_decoder");
        $finish;
    end

    // hung handshake or lost results
    initial begin
        #1000000;
        $display("FAIL tga_rle_pixel_decoder");
        $finish;
    end

endmodule

// ===== files.f =====
src/trpd_pkg.sv
src/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_decoder_test.sv
